// ===== hw/rtl/rpf_pkg.sv =====
// shared constants for the repeated element filter
package rpf_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned REPEAT_W      = 6;
  localparam int unsigned KEPT_W        = 7;

endpackage

// ===== hw/rtl/rpf_store.sv =====
// element store: one write port, one read port, registered read data
module rpf_store #(
  parameter  int unsigned DEPTH  = rpf_pkg::MAX_ITEMS_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [rpf_pkg::VALUE_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [rpf_pkg::VALUE_W-1:0]  rd_data
);

  logic [rpf_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/repeated_element_filter.sv =====
// repeated element filter: list store, pairwise scan and result sequencer
// after the request marked last, each stored element in turn passes fetch, hold, a scan over all stored
//   elements and drain before its result shows; the single read port of the element store sets this pace,
//   and the next element is fetched only once the output has taken the current result
// input requests are taken one per cycle while loading; no request is taken during emission
// reset clears the element count, the overflow flag and all handshake state; the store is not cleared
module repeated_element_filter #(
  parameter int unsigned MAX_ITEMS = rpf_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rpf_pkg::VALUE_W-1:0]  value,
  input  logic                                last,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rpf_pkg::VALUE_W-1:0]  value_res,
  output logic [rpf_pkg::REPEAT_W-1:0]        repeat_count,
  output logic                                kept,
  output logic [rpf_pkg::KEPT_W-1:0]          kept_so_far,
  output logic                                overflowed,
  output logic                                last_res
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  // load: take list elements; fetch/hold: read element i into cur_val;
  // scan: stream every stored element past cur_val; drain: last compare; emit: hand out result
  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_HOLD,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            count;        // stored elements of the current run
  logic                        ovf;          // a request was dropped for lack of room
  logic [IDX_W-1:0]            idx_i;        // element being reported
  logic [IDX_W-1:0]            idx_j;        // element being read during the scan
  logic [IDX_W-1:0]            cmp_idx;      // index of the word now on the read data
  logic                        cmp_valid;    // read data holds a scan word
  logic [IDX_W-1:0]            reps;         // matches found so far for element i
  logic [CNT_W-1:0]            kept_total;   // running number of kept elements
  logic [rpf_pkg::VALUE_W-1:0] cur_val;

  // store port controls
  logic                        wr_en;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [rpf_pkg::VALUE_W-1:0] rd_data;

  logic                        in_acc;
  logic                        room;
  logic                        hit;
  logic [CNT_W-1:0]            cnt_last;
  logic [IDX_W-1:0]            reps_fin;
  logic [CNT_W-1:0]            kept_total_next;

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign room     = (count < CNT_W'(MAX_ITEMS));
  assign cnt_last = count - CNT_W'(1);

  // a match counts only against another position
  assign hit = cmp_valid && (cmp_idx != idx_i) && (rd_data == cur_val);
  assign reps_fin = reps + IDX_W'(hit);
  assign kept_total_next = kept_total + CNT_W'(reps_fin != '0);

  always_comb begin
    wr_en   = in_acc && room;
    rd_en   = (state == S_FETCH) || (state == S_SCAN);
    rd_addr = (state == S_FETCH) ? idx_i : idx_j;
  end

  rpf_store #(
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
      kept_total <= '0;
      cmp_valid  <= 1'b0;
    end else begin
      // compare stage works on each scan read in the following cycle
      cmp_valid <= (state == S_SCAN);
      cmp_idx   <= idx_j;
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              idx_i      <= '0;
              kept_total <= '0;
              state      <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_HOLD;
        end
        S_HOLD: begin
          cur_val <= rd_data;
          idx_j   <= '0;
          reps    <= '0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          reps <= reps_fin;
          if (CNT_W'(idx_j) == cnt_last) begin
            state <= S_DRAIN;
          end else begin
            idx_j <= idx_j + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          // last compare lands here; load the output register
          value_res    <= cur_val;
          repeat_count <= rpf_pkg::REPEAT_W'(reps_fin);
          kept         <= (reps_fin != '0);
          kept_so_far  <= rpf_pkg::KEPT_W'(kept_total_next);
          kept_total   <= kept_total_next;
          overflowed   <= ovf;
          last_res     <= (CNT_W'(idx_i) == cnt_last);
          out_valid    <= 1'b1;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_res) begin
              // end of run: list and overflow mark start over
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              idx_i <= idx_i + IDX_W'(1);
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // element count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond store depth");

  // final result of a run empties the list and clears the overflow mark
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_res |=> (count == '0) && !ovf)
    else $error("run state not cleared after final result");

  // kept flag follows the repeat count, and the running total never passes the position
  a_kept_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kept == (repeat_count != '0)) &&
                  (kept_so_far <= rpf_pkg::KEPT_W'(idx_i) + rpf_pkg::KEPT_W'(1)))
    else $error("kept flag or running total inconsistent");

  // no request is taken while a result is pending
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during emission");
`endif

endmodule

// ===== dv/rpf_checker.sv =====
// result predictor and scoreboard for the repeated element filter
module rpf_checker #(
  parameter int unsigned MAX_ITEMS = rpf_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [rpf_pkg::VALUE_W-1:0]  value,
  input  logic                                last,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [rpf_pkg::VALUE_W-1:0]  value_res,
  input  logic [rpf_pkg::REPEAT_W-1:0]        repeat_count,
  input  logic                                kept,
  input  logic [rpf_pkg::KEPT_W-1:0]          kept_so_far,
  input  logic                                overflowed,
  input  logic                                last_res,
  output int                                  mismatches,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [rpf_pkg::VALUE_W-1:0] elem;
    logic [rpf_pkg::REPEAT_W-1:0]       reps;
    logic                               keep;
    logic [rpf_pkg::KEPT_W-1:0]         keep_run;
    logic                               dropped;
    logic                               fin;
  } dup_result_t;

  logic signed [rpf_pkg::VALUE_W-1:0] list_store [MAX_ITEMS];
  int unsigned                        list_len;
  bit                                 list_dropped;
  dup_result_t                        expected_dups [$];

  // one expected result per stored element, scanned against the whole list
  task automatic tally_duplicates();
    int unsigned reps;
    int unsigned keep_total;
    dup_result_t r;
    keep_total = 0;
    for (int unsigned i = 0; i < list_len; i++) begin
      reps = 0;
      for (int unsigned j = 0; j < list_len; j++)
        if (j != i && list_store[j] == list_store[i]) reps++;
      if (reps != 0) keep_total++;
      r.elem     = list_store[i];
      r.reps     = reps[rpf_pkg::REPEAT_W-1:0];
      r.keep     = (reps != 0);
      r.keep_run = keep_total[rpf_pkg::KEPT_W-1:0];
      r.dropped  = list_dropped;
      r.fin      = (i + 1 == list_len);
      expected_dups.push_back(r);
    end
    list_len     = 0;
    list_dropped = 0;
  endtask

  task automatic check_result();
    dup_result_t got;
    dup_result_t want;
    got = '{value_res, repeat_count, kept, kept_so_far, overflowed, last_res};
    if (expected_dups.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result value_res=%0d repeat_count=%0d", $realtime,
                 got.elem, got.reps);
    end else begin
      want = expected_dups.pop_front();
      if (got.elem !== want.elem || got.reps !== want.reps || got.keep !== want.keep ||
          got.keep_run !== want.keep_run || got.dropped !== want.dropped ||
          got.fin !== want.fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp value=%0d reps=%0d kept=%0b run=%0d ovf=%0b last=%0b",
                    " got value=%0d reps=%0d kept=%0b run=%0d ovf=%0b last=%0b"},
                   $realtime, want.elem, want.reps, want.keep, want.keep_run, want.dropped,
                   want.fin, got.elem, got.reps, got.keep, got.keep_run, got.dropped,
                   got.fin);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_len     = 0;
      list_dropped = 0;
      expected_dups.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        if (list_len < MAX_ITEMS) begin
          list_store[list_len] = value;
          list_len++;
        end else begin
          list_dropped = 1;
        end
        if (last) tally_duplicates();
      end
    end
    pending = expected_dups.size();
  end

endmodule

// ===== dv/repeated_element_filter_tb.sv =====
// stimulus, handshake timing and verdict for the repeated element filter
module repeated_element_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ITEMS    = rpf_pkg::MAX_ITEMS_DEF;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  // extra wait once no result is pending, scaled with the store depth
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_ITEMS + 16;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [rpf_pkg::VALUE_W-1:0]  value = '0;
  logic                                last = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [rpf_pkg::VALUE_W-1:0]  value_res;
  logic [rpf_pkg::REPEAT_W-1:0]        repeat_count;
  logic                                kept;
  logic [rpf_pkg::KEPT_W-1:0]          kept_so_far;
  logic                                overflowed;
  logic                                last_res;

  int                                  fail_count;
  int                                  pending_count;

  idle_mode_t                          idle_mode = IDLE_NONE;
  // the stimulus bumps this to ask the receiver for one long hold-off
  int unsigned                         hold_requests = 0;
  logic signed [rpf_pkg::VALUE_W-1:0]  list_buf [$];

  repeated_element_filter #(.MAX_ITEMS(MAX_ITEMS)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value_res    (value_res),
    .repeat_count (repeat_count),
    .kept         (kept),
    .kept_so_far  (kept_so_far),
    .overflowed   (overflowed),
    .last_res     (last_res)
  );

  rpf_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value_res    (value_res),
    .repeat_count (repeat_count),
    .kept         (kept),
    .kept_so_far  (kept_so_far),
    .overflowed   (overflowed),
    .last_res     (last_res),
    .mismatches   (fail_count),
    .pending      (pending_count)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: a hung block ends the run here
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 65;
      IDLE_BOTH:   return $urandom_range(0, 99) < 16;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 65;
      IDLE_BOTH:     return $urandom_range(0, 99) < 16;
      default:       return 1'b0;
    endcase
  endfunction

  // result side: random stall per cycle, plus one long counted hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= receiver_stalls();
      end
    end
  end

  // offer one request from a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests drop valid in between only when the sender idles
  task automatic send_request(input logic signed [rpf_pkg::VALUE_W-1:0] v, input logic l);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    // in_stall read right after the edge still holds its pre-edge value
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // the whole buffered list goes out, the final request marked last
  task automatic send_list();
    for (int i = 0; i < list_buf.size(); i++)
      send_request(list_buf[i], i == list_buf.size() - 1);
    list_buf.delete();
  endtask

  // random list content: some lists draw from a narrow window so duplicates are common,
  // others are full-range or built from corner values
  task automatic build_list(input int unsigned len);
    int unsigned flavor;
    int unsigned span;
    logic signed [rpf_pkg::VALUE_W-1:0] base;
    logic signed [rpf_pkg::VALUE_W-1:0] corners [6];
    corners = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1, 32'sh5555_5555,
                32'shaaaa_aaaa};
    flavor = $urandom_range(0, 3);
    base   = $urandom;
    span   = $urandom_range(0, len);
    for (int unsigned i = 0; i < len; i++) begin
      case (flavor)
        0:       list_buf.push_back($urandom);
        1:       list_buf.push_back(base + $urandom_range(0, span));
        2:       list_buf.push_back($urandom_range(0, 1) ? $urandom : base +
                                    $urandom_range(0, 3));
        default: list_buf.push_back(corners[$urandom_range(0, 5)]);
      endcase
    end
  endtask

  initial begin
    int unsigned items_sent;
    int unsigned list_idx;
    int unsigned len;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: single element at the negative extreme, never a repeat
    list_buf = '{32'sh8000_0000};
    send_list();
    // extremes with repeats mixed among unique values
    list_buf = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sh1, 32'sh7fff_ffff,
                 32'sh8000_0000, 32'sh8000_0000};
    send_list();
    // a pair, then a list where every element is the same
    list_buf = '{32'sd5, 32'sd5};
    send_list();
    list_buf = '{32'sd7, 32'sd7, 32'sd7, 32'sd7, 32'sd7};
    send_list();
    // alternating bit patterns, every input bit toggles
    list_buf = '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555};
    send_list();

    // random lists; idling mode rotates every three lists
    items_sent = 0;
    list_idx   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      idle_mode = idle_mode_t'((list_idx / 3) % 4);
      // store exactly full, overflow by the last request, and overflow by several
      if (list_idx == 1)       len = MAX_ITEMS;
      else if (list_idx == 4)  len = MAX_ITEMS + 1;
      else if (list_idx == 8)  len = MAX_ITEMS + 6;
      else if ($urandom_range(0, 24) == 0) len = $urandom_range(MAX_ITEMS / 2, MAX_ITEMS + 8);
      else len = $urandom_range(1, 10);
      // long receiver hold-off while this list and the next keep the sender busy
      if (list_idx == 6) hold_requests++;
      build_list(len);
      send_list();
      items_sent += len;
      list_idx++;
    end
    in_valid <= 1'b0;

    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
